[src/mos_pkg.sv]
// ----------------------------------------------------------------------------
// mos_pkg
// Shared types and constants for the median-of-sample-set block: beat
// payloads, field widths and the control word driven into the sort chain.
// ----------------------------------------------------------------------------
`default_nettype none

package mos_pkg;

  localparam int unsigned SampleW        = 32;
  localparam int unsigned CountW         = 7;
  localparam int unsigned MaxSamplesDef  = 64;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      present;
    logic                      last;
  } mos_in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] median;
    logic [CountW-1:0]         sample_count;
    logic                      overflowed;
  } mos_out_t;

  // per-cycle command to every cell of the chain
  typedef struct packed {
    logic ins;   // place a new sample
    logic shl;   // move every value one cell toward cell 0
  } mos_cell_ctrl_t;

endpackage

`default_nettype wire

[src/mos_cell.sv]
// ----------------------------------------------------------------------------
// mos_cell
// One entry of the insertion sort chain. Holds one sample; on insert it
// either keeps its value, takes its lower neighbor's value or takes the new
// sample; on a left shift it takes its upper neighbor's value.
// ----------------------------------------------------------------------------
`default_nettype none

module mos_cell
  import mos_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire mos_cell_ctrl_t            ctrl_i,
  input  wire logic signed [SampleW-1:0] x_i,
  input  wire logic                      occ_i,
  input  wire logic                      at_end_i,
  input  wire logic signed [SampleW-1:0] left_val_i,
  input  wire logic                      left_gt_i,
  input  wire logic signed [SampleW-1:0] right_val_i,
  output      logic signed [SampleW-1:0] val_o,
  output      logic                      gt_o
);

  logic signed [SampleW-1:0] val_q, val_d;

  assign gt_o  = occ_i && (val_q > x_i);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.ins) begin
      if (gt_o || at_end_i) begin
        val_d = left_gt_i ? left_val_i : x_i;
      end
    end else if (ctrl_i.shl) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

`default_nettype wire

[src/median_of_sample_set_top.sv]
// ----------------------------------------------------------------------------
// median_of_sample_set_top
// Median of a set of signed Q16.16 samples kept in an insertion sort chain.
// ----------------------------------------------------------------------------
// A sample beat is placed into the sorted chain of MAX_SAMPLES cells as it
// is accepted, so samples stream in back to back. A beat with last set closes
// the set. The chain then shifts s cells toward cell 0 until the middle
// element sits in cell 0: s = (n-1)/2 for an odd count n and s = n/2-1 for an
// even count. ST_SUM then loads the output register with cell 0 for an odd
// count or the average of the two middle values for an even count. The input
// side is held off during the shift and ST_SUM, and for longer while an
// earlier result still waits in the output register. The shift length through
// the chain thus sets the cost of a closing beat. An empty set reports 0, and
// samples beyond the chain's capacity are dropped and reported by the
// overflowed flag.
// ----------------------------------------------------------------------------
`default_nettype none

module median_of_sample_set_top
  import mos_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = MaxSamplesDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output      logic     in_ready_o,
  input  wire mos_in_t  in_data_i,
  output      logic     out_valid_o,
  input  wire logic     out_ready_i,
  output      mos_out_t out_data_o
);

  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned Idx1 = (MAX_SAMPLES > 1) ? 1 : 0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_SUM
  } state_e;

  state_e                    state_q, state_d;
  logic [CntW-1:0]           count_q, count_d;
  logic                      drop_q, drop_d;
  logic [CntW-1:0]           n_q, n_d;
  logic [CntW-1:0]           sh_q, sh_d;
  logic                      ovf_q, ovf_d;
  logic                      out_valid_q, out_valid_d;
  mos_out_t                  out_q, out_d;

  mos_cell_ctrl_t            ctrl;
  logic signed [SampleW-1:0] vals [MAX_SAMPLES];
  logic                      gts  [MAX_SAMPLES];

  logic                      accept;
  logic                      room;
  logic [CntW-1:0]           n_new;
  logic signed [SampleW:0]   mid_sum;
  logic [CntW+CountW-1:0]    n_ext;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign room        = (count_q < CntW'(MAX_SAMPLES));
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign ctrl.ins = accept && in_data_i.present && room;
  assign ctrl.shl = (state_q == ST_DRAIN) && (sh_q != '0);

  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    logic signed [SampleW-1:0] left_val, right_val;
    logic                      left_gt;
    if (i == 0) begin : g_first
      assign left_val = in_data_i.sample;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_val = vals[i-1];
      assign left_gt  = gts[i-1];
    end
    if (i == MAX_SAMPLES - 1) begin : g_lastc
      assign right_val = vals[i];
    end else begin : g_inner
      assign right_val = vals[i+1];
    end
    mos_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .x_i         (in_data_i.sample),
      .occ_i       (CntW'(i) < count_q),
      .at_end_i    (CntW'(i) == count_q),
      .left_val_i  (left_val),
      .left_gt_i   (left_gt),
      .right_val_i (right_val),
      .val_o       (vals[i]),
      .gt_o        (gts[i])
    );
  end

  assign n_new   = ctrl.ins ? count_q + CntW'(1) : count_q;
  assign mid_sum = {vals[0][SampleW-1], vals[0]} + {vals[Idx1][SampleW-1], vals[Idx1]};
  assign n_ext   = {{CountW{1'b0}}, n_q};

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    drop_d      = drop_q;
    n_d         = n_q;
    sh_d        = sh_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          count_d = n_new;
          if (in_data_i.present && !room) begin
            drop_d = 1'b1;
          end
          if (in_data_i.last) begin
            n_d     = n_new;
            ovf_d   = drop_q || (in_data_i.present && !room);
            count_d = '0;
            drop_d  = 1'b0;
            if (n_new == '0) begin
              sh_d = '0;
            end else if (n_new[0]) begin
              sh_d = n_new >> 1;
            end else begin
              sh_d = (n_new >> 1) - CntW'(1);
            end
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (sh_q == '0) begin
          state_d = ST_SUM;
        end else begin
          sh_d = sh_q - CntW'(1);
        end
      end
      ST_SUM: begin
        if (!out_valid_q || out_ready_i) begin
          if (n_q == '0) begin
            out_d.median = '0;
          end else if (n_q[0]) begin
            out_d.median = vals[0];
          end else begin
            out_d.median = mid_sum[SampleW:1];
          end
          out_d.sample_count = n_ext[CountW-1:0];
          out_d.overflowed   = ovf_q;
          out_valid_d        = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    sh_q  <= sh_d;
    ovf_q <= ovf_d;
    out_q <= out_d;
  end

endmodule

`default_nettype wire
